FILE: rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the HTTP chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

   localparam int SIZE_W         = 32;  // chunk size and size limit width
   localparam int RCOUNT_W       = 32;  // width of the reported byte count
   localparam int HEX_DIGIT_BITS = 4;   // radix 16

   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_LF = 8'h0A;

   // Configuration register indexes
   localparam logic CSR_CHUNKED_MODE   = 1'b0;
   localparam logic CSR_MAX_BODY_BYTES = 1'b1;

   typedef enum logic [5:0] {
      PH_SIZE    = 6'b000001,
      PH_SIZE_LF = 6'b000010,
      PH_DATA    = 6'b000100,
      PH_DATA_CR = 6'b001000,
      PH_DATA_LF = 6'b010000,
      PH_TRAILER = 6'b100000
   } phase_type;

   typedef struct packed {
      logic       new_body;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic                out_valid;
      logic [7:0]          out_byte;
      logic                body_done;
      logic                overflow;
      logic [RCOUNT_W-1:0] received_count;
   } rsp_type;

   // {is_hex, value}
   function automatic logic [HEX_DIGIT_BITS:0] hex_digit(input logic [7:0] b);
      logic [HEX_DIGIT_BITS:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, 4'(b[3:0] + 4'd9)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/hcbd_skid.sv
// ----------------------------------------------------------------------------
// hcbd_skid
// Two-entry result buffer: output register plus skid register, so the
// upstream stall is a registered signal and a beat is taken while the
// output register is held.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_skid (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire hcbd_pkg::rsp_type in_data,
   output logic                  in_stall,
   output logic                  out_valid,
   output hcbd_pkg::rsp_type     out_data,
   input  wire logic             out_stall
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   hcbd_pkg::rsp_type main_data_ff,  main_data_in;
   hcbd_pkg::rsp_type skid_data_ff,  skid_data_in;

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || !out_stall) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_data_in  = in_data;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

FILE: rtl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Byte-serial decoder of HTTP/1.1 response bodies, plain or chunked.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one body byte per beat, new_body set on the first byte of a
//   response (clears decoder state, keeps the registers).
//   rsp channel: exactly one result beat per request beat, in order.
//   csr port: index 0 chunked_mode, index 1 max_body_bytes; write only while
//   the block is idle.
// Throughput: one byte per clock while req_stall is low. The decode of a
// byte and the state update are done in the cycle it is accepted; the result
// is registered in the output register, or in the skid register while held.
// Reset: synchronous; registers back to 0 (plain mode, no limit), decoder in
// the size-line phase, result buffer empty.
// Stall: the result buffer holds two beats. While rsp_stall holds the output
// register, one more beat is taken into the skid register; then req_stall
// rises until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder #(
   parameter int SIZE_LINE_BUF = 16,
   parameter int COUNT_BITS    = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire hcbd_pkg::req_type          req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output hcbd_pkg::rsp_type               rsp_data,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [hcbd_pkg::SIZE_W-1:0] csr_wdata
);

   localparam int CW    = $clog2(SIZE_LINE_BUF);
   localparam int CMP_W = (COUNT_BITS > hcbd_pkg::SIZE_W) ? COUNT_BITS : hcbd_pkg::SIZE_W;
   localparam int AW    = hcbd_pkg::SIZE_W;
   localparam int HB    = hcbd_pkg::HEX_DIGIT_BITS;
   localparam logic [CW-1:0] CNT_LIMIT = CW'(SIZE_LINE_BUF - 1);

   // configuration
   logic          chunked_mode_ff;
   logic [AW-1:0] max_body_bytes_ff;

   // decoder state
   hcbd_pkg::phase_type   chunk_phase_ff,         chunk_phase_in;
   logic [CW-1:0]         size_char_count_ff,     size_char_count_in;
   logic [AW-1:0]         size_accumulator_ff,    size_accumulator_in;
   logic                  size_digits_stopped_ff, size_digits_stopped_in;
   logic [AW-1:0]         chunk_left_ff,          chunk_left_in;
   logic [COUNT_BITS-1:0] body_count_ff,          body_count_in;
   logic                  finished_ff,            finished_in;
   logic                  overflow_ff,            overflow_in;

   logic              accept;
   logic              res_stall;
   hcbd_pkg::rsp_type res;

   // decode temporaries
   hcbd_pkg::phase_type   ph_base;
   logic [CW-1:0]         cnt_base;
   logic [AW-1:0]         acc_base;
   logic                  stop_base;
   logic [AW-1:0]         left_base;
   logic [COUNT_BITS-1:0] bc_base;
   logic                  fin_base;
   logic                  ovf_base;
   logic [COUNT_BITS-1:0] bc_inc;
   logic [CMP_W-1:0]      bc_ext;
   logic                  limit_hit;
   logic [HB:0]           hex;
   logic [AW-1:0]         left_dec;
   logic                  take;
   logic                  deliver;
   logic [7:0]            b;
   logic [CMP_W-1:0]      bc_out_ext;

   assign req_stall = res_stall;
   assign accept    = req_valid && !res_stall;
   assign b         = req_data.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunked_mode_ff   <= 1'b0;
         max_body_bytes_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            hcbd_pkg::CSR_CHUNKED_MODE:   chunked_mode_ff   <= csr_wdata[0];
            hcbd_pkg::CSR_MAX_BODY_BYTES: max_body_bytes_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      // new_body clears the body state before the byte is decoded
      if (req_data.new_body) begin
         ph_base   = hcbd_pkg::PH_SIZE;
         cnt_base  = '0;
         acc_base  = '0;
         stop_base = 1'b0;
         left_base = '0;
         bc_base   = '0;
         fin_base  = 1'b0;
         ovf_base  = 1'b0;
      end else begin
         ph_base   = chunk_phase_ff;
         cnt_base  = size_char_count_ff;
         acc_base  = size_accumulator_ff;
         stop_base = size_digits_stopped_ff;
         left_base = chunk_left_ff;
         bc_base   = body_count_ff;
         fin_base  = finished_ff;
         ovf_base  = overflow_ff;
      end

      bc_inc    = (bc_base == '1) ? bc_base : bc_base + COUNT_BITS'(1);
      bc_ext    = CMP_W'(bc_base);
      limit_hit = (max_body_bytes_ff != '0) && (bc_ext >= CMP_W'(max_body_bytes_ff));
      hex       = hcbd_pkg::hex_digit(b);
      left_dec  = (left_base != '0) ? left_base - AW'(1) : left_base;

      chunk_phase_in         = ph_base;
      size_char_count_in     = cnt_base;
      size_accumulator_in    = acc_base;
      size_digits_stopped_in = stop_base;
      chunk_left_in          = left_base;
      take                   = 1'b0;

      if (!fin_base) begin
         if (!chunked_mode_ff) begin
            take = 1'b1;
         end else begin
            unique case (ph_base)
               hcbd_pkg::PH_SIZE: begin
                  if (b == hcbd_pkg::BYTE_CR) begin
                     chunk_phase_in = hcbd_pkg::PH_SIZE_LF;
                  end else if (cnt_base < CNT_LIMIT) begin
                     size_char_count_in = cnt_base + CW'(1);
                     if (!stop_base) begin
                        if (!hex[HB]) begin
                           size_digits_stopped_in = 1'b1;
                        end else if (acc_base[AW-1 -: HB] != '0) begin
                           size_accumulator_in = '1;  // saturate
                        end else begin
                           size_accumulator_in = {acc_base[AW-HB-1:0], hex[HB-1:0]};
                        end
                     end
                  end
               end
               hcbd_pkg::PH_SIZE_LF: begin
                  if (b == hcbd_pkg::BYTE_LF) begin
                     chunk_left_in          = acc_base;
                     size_char_count_in     = '0;
                     size_accumulator_in    = '0;
                     size_digits_stopped_in = 1'b0;
                     chunk_phase_in         = (acc_base == '0) ? hcbd_pkg::PH_TRAILER
                                                               : hcbd_pkg::PH_DATA;
                  end
               end
               hcbd_pkg::PH_DATA: begin
                  chunk_left_in = left_dec;
                  take          = 1'b1;
                  if (left_dec == '0) begin
                     chunk_phase_in = hcbd_pkg::PH_DATA_CR;
                  end
               end
               hcbd_pkg::PH_DATA_CR: begin
                  if (b == hcbd_pkg::BYTE_CR) begin
                     chunk_phase_in = hcbd_pkg::PH_DATA_LF;
                  end
               end
               hcbd_pkg::PH_DATA_LF: begin
                  if (b == hcbd_pkg::BYTE_LF) begin
                     chunk_phase_in = hcbd_pkg::PH_SIZE;
                  end
               end
               hcbd_pkg::PH_TRAILER: begin
                  if (b == hcbd_pkg::BYTE_LF) begin
                     take = 1'b0;
                  end
               end
               default: begin
                  take = 1'b0;
               end
            endcase
         end
      end

      // payload byte: counted always, delivered unless over the limit
      body_count_in = take ? bc_inc : bc_base;
      deliver       = take && !limit_hit;
      overflow_in   = ovf_base || (take && limit_hit);
      finished_in   = fin_base || (take && limit_hit)
                      || (!fin_base && chunked_mode_ff && ph_base == hcbd_pkg::PH_TRAILER
                          && b == hcbd_pkg::BYTE_LF);

      bc_out_ext         = CMP_W'(body_count_in);
      res.out_valid      = deliver;
      res.out_byte       = deliver ? b : 8'h00;
      res.body_done      = finished_in;
      res.overflow       = overflow_in;
      res.received_count = bc_out_ext[hcbd_pkg::RCOUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_phase_ff         <= hcbd_pkg::PH_SIZE;
         size_char_count_ff     <= '0;
         size_accumulator_ff    <= '0;
         size_digits_stopped_ff <= 1'b0;
         chunk_left_ff          <= '0;
         body_count_ff          <= '0;
         finished_ff            <= 1'b0;
         overflow_ff            <= 1'b0;
      end else if (accept) begin
         chunk_phase_ff         <= chunk_phase_in;
         size_char_count_ff     <= size_char_count_in;
         size_accumulator_ff    <= size_accumulator_in;
         size_digits_stopped_ff <= size_digits_stopped_in;
         chunk_left_ff          <= chunk_left_in;
         body_count_ff          <= body_count_in;
         finished_ff            <= finished_in;
         overflow_ff            <= overflow_in;
      end
   end

   hcbd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (res),
      .in_stall  (res_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HTTP chunked body decoder.
// A short directed walk covers plain pass-through, a full chunked body with
// stray bytes, the trailer, bytes after the end and the size limit. Random
// bodies follow, mostly well-formed chunked streams with noise, over several
// register settings. Beats are compared with a local model or a typed want.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIZE_LINE_BUF = 16;
   localparam int LINE_CHAR_MAX = SIZE_LINE_BUF - 1;
   localparam int RANDOM_ITEMS  = 950;
   localparam int CYCLE_LIMIT   = 400000;

   logic                        clock;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   hcbd_pkg::req_type           req_data  = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   hcbd_pkg::rsp_type           rsp_data;
   logic                        csr_we    = 1'b0;
   logic                        csr_index = 1'b0;
   logic [hcbd_pkg::SIZE_W-1:0] csr_wdata = '0;

   http_chunked_body_decoder #(
      .SIZE_LINE_BUF (SIZE_LINE_BUF),
      .COUNT_BITS    (hcbd_pkg::RCOUNT_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------
   bit                            cfg_chunked;
   logic [hcbd_pkg::SIZE_W-1:0]   cfg_limit;

   hcbd_pkg::phase_type           ph;
   logic [3:0]                    line_chars;
   logic [hcbd_pkg::SIZE_W-1:0]   line_value;
   bit                            line_stopped;
   logic [hcbd_pkg::SIZE_W-1:0]   chunk_rem;
   logic [hcbd_pkg::RCOUNT_W-1:0] body_cnt;
   bit                            body_fin;
   bit                            body_ovf;

   function automatic void clear_decoder();
      ph           = hcbd_pkg::PH_SIZE;
      line_chars   = '0;
      line_value   = '0;
      line_stopped = 1'b0;
      chunk_rem    = '0;
      body_cnt     = '0;
      body_fin     = 1'b0;
      body_ovf     = 1'b0;
   endfunction

   function automatic int hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   // counts a body byte; 0 when the limit swallows it
   function automatic bit count_payload();
      logic [hcbd_pkg::RCOUNT_W-1:0] prior;
      prior = body_cnt;
      if (body_cnt != '1) body_cnt++;
      if (cfg_limit != '0 && prior >= cfg_limit) begin
         body_ovf = 1'b1;
         body_fin = 1'b1;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic hcbd_pkg::rsp_type decode_byte(hcbd_pkg::req_type r);
      hcbd_pkg::rsp_type res;
      bit                deliver;
      int                d;
      logic [7:0]        b;
      b       = r.data_byte;
      deliver = 1'b0;
      if (r.new_body) clear_decoder();
      if (!body_fin) begin
         if (!cfg_chunked) begin
            deliver = count_payload();
         end else begin
            case (ph)
               hcbd_pkg::PH_SIZE: begin
                  if (b == hcbd_pkg::BYTE_CR) begin
                     ph = hcbd_pkg::PH_SIZE_LF;
                  end else if (line_chars < LINE_CHAR_MAX) begin
                     line_chars++;
                     if (!line_stopped) begin
                        d = hex_nibble(b);
                        if (d < 0) line_stopped = 1'b1;
                        else if (line_value > 32'h0FFF_FFFF) line_value = '1;
                        else line_value = {line_value[hcbd_pkg::SIZE_W-5:0], 4'(d)};
                     end
                  end
               end
               hcbd_pkg::PH_SIZE_LF: begin
                  if (b == hcbd_pkg::BYTE_LF) begin
                     chunk_rem    = line_value;
                     line_chars   = '0;
                     line_value   = '0;
                     line_stopped = 1'b0;
                     ph = (chunk_rem == '0) ? hcbd_pkg::PH_TRAILER : hcbd_pkg::PH_DATA;
                  end
               end
               hcbd_pkg::PH_DATA: begin
                  if (chunk_rem != '0) chunk_rem--;
                  deliver = count_payload();
                  if (chunk_rem == '0) ph = hcbd_pkg::PH_DATA_CR;
               end
               hcbd_pkg::PH_DATA_CR: if (b == hcbd_pkg::BYTE_CR) ph = hcbd_pkg::PH_DATA_LF;
               hcbd_pkg::PH_DATA_LF: if (b == hcbd_pkg::BYTE_LF) ph = hcbd_pkg::PH_SIZE;
               hcbd_pkg::PH_TRAILER: if (b == hcbd_pkg::BYTE_LF) body_fin = 1'b1;
               default: ;
            endcase
         end
      end
      res.out_valid      = deliver;
      res.out_byte       = deliver ? b : 8'h00;
      res.body_done      = body_fin;
      res.overflow       = body_ovf;
      res.received_count = body_cnt;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   hcbd_pkg::rsp_type pending_rsp[$];
   int      errors        = 0;
   int      beats_checked = 0;
   int      stall_left    = 0;
   bit      quiet         = 1'b0;

   function automatic void check_field(string what, logic [31:0] want_v,
                                       logic [31:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0h, got %0h",
                  $time, what, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin : rx_side
      hcbd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t ns: result beat with nothing outstanding, expected none, got %h",
                     $time, rsp_data);
         end else begin
            want = pending_rsp[0];
            pending_rsp.delete(0);
            check_field("out_valid", 32'(want.out_valid), 32'(rsp_data.out_valid));
            check_field("out_byte", 32'(want.out_byte), 32'(rsp_data.out_byte));
            check_field("body_done", 32'(want.body_done), 32'(rsp_data.body_done));
            check_field("overflow", 32'(want.overflow), 32'(rsp_data.overflow));
            check_field("received_count", want.received_count,
                        rsp_data.received_count);
            beats_checked++;
         end
      end
      // short back-pressure bursts, none in the quiet window
      if (stall_left == 0 && !reset && !quiet && $urandom_range(0, 99) < 3)
         stall_left = $urandom_range(1, 4);
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   int live_items   = 0;
   int bytes_out    = 0;
   int bodies_ended = 0;
   int overflows    = 0;
   int settings     = 0;
   bit next_fresh   = 1'b0;

   task automatic push_beat(input bit nb, input logic [7:0] b, input bit typed,
                            input hcbd_pkg::rsp_type want);
      hcbd_pkg::req_type r;
      hcbd_pkg::rsp_type got;
      bit                fin_prior;
      bit                ovf_prior;
      r.new_body  = nb;
      r.data_byte = b;
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fin_prior = body_fin && !nb;
      ovf_prior = body_ovf && !nb;
      got = decode_byte(r);
      pending_rsp.insert(pending_rsp.size(), typed ? want : got);
      live_items++;
      if (got.out_valid) bytes_out++;
      if (got.body_done && !fin_prior) bodies_ended++;
      if (got.overflow && !ovf_prior) overflows++;
      quiet = (live_items >= 350 && live_items < 520);
   endtask

   task automatic idle_maybe();
      if (!quiet && $urandom_range(0, 99) < 3) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_regs(input bit mode, input logic [hcbd_pkg::SIZE_W-1:0] limit);
      csr_we    <= 1'b1;
      csr_index <= hcbd_pkg::CSR_CHUNKED_MODE;
      csr_wdata <= hcbd_pkg::SIZE_W'(mode);
      @(posedge clock);
      csr_index <= hcbd_pkg::CSR_MAX_BODY_BYTES;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we      <= 1'b0;
      cfg_chunked = mode;
      cfg_limit   = limit;
      settings++;
   endtask

   // body byte; occasionally preceded by a stray byte
   task automatic put_byte(input logic [7:0] b);
      bit nb;
      nb = next_fresh;
      next_fresh = 1'b0;
      if (!nb && $urandom_range(0, 99) < 3) begin
         push_beat(1'b0, 8'($urandom_range(0, 255)), 1'b0, '0);
         idle_maybe();
      end
      push_beat(nb, b, 1'b0, '0);
      idle_maybe();
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 10) return 8'("0") + 8'(n);
      if ($urandom_range(0, 1) != 0) return 8'("A") + 8'(n) - 8'd10;
      return 8'("a") + 8'(n) - 8'd10;
   endfunction

   task automatic put_size_digits(input logic [hcbd_pkg::SIZE_W-1:0] v, input int width);
      int ndig;
      ndig = 1;
      while (ndig < 8 && (v >> (4 * ndig)) != 0) ndig++;
      if (width < ndig) width = ndig;
      for (int i = width - 1; i >= 0; i--)
         put_byte(hex_char(i < ndig ? v[4*i +: 4] : 4'd0));
   endtask

   task automatic chunked_body(input bit fresh);
      int n_chunks;
      int style;
      int sz;
      bit huge;
      next_fresh = fresh;
      n_chunks = $urandom_range(0, 4);
      for (int c = 0; c <= n_chunks; c++) begin
         style = $urandom_range(0, 19);
         huge  = 1'b0;
         if (c == n_chunks) sz = 0;
         else if ($urandom_range(0, 19) == 0) sz = $urandom_range(100, 300);
         else sz = $urandom_range(1, 24);
         if (style == 0) begin
            // zero-padded to fill the line buffer: the trailing digits fall off
            put_size_digits(hcbd_pkg::SIZE_W'(sz), LINE_CHAR_MAX);
            repeat ($urandom_range(1, 3)) put_byte(hex_char(4'($urandom_range(0, 15))));
         end else if (style == 1) begin
            put_byte(hex_char(4'hF));
            repeat ($urandom_range(8, 10)) put_byte(hex_char(4'($urandom_range(0, 15))));
            huge = 1'b1;
         end else if (style == 2) begin
            // no digits at all reads as the last chunk
            sz = 0;
            if ($urandom_range(0, 1) != 0) put_byte(";");
         end else begin
            put_size_digits(hcbd_pkg::SIZE_W'(sz), $urandom_range(0, 3));
            if (style == 3) begin
               put_byte(";");
               repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(8'h21, 8'h7E)));
            end
         end
         put_byte(hcbd_pkg::BYTE_CR);
         put_byte(hcbd_pkg::BYTE_LF);
         if (huge) begin
            repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(0, 255)));
            return;
         end
         if (sz == 0) break;
         repeat (sz) put_byte(8'($urandom_range(0, 255)));
         put_byte(hcbd_pkg::BYTE_CR);
         put_byte(hcbd_pkg::BYTE_LF);
      end
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(8'h0B, 8'hFF)));
      put_byte(hcbd_pkg::BYTE_LF);
   endtask

   task automatic plain_burst(input bit fresh);
      next_fresh = fresh;
      repeat ($urandom_range(4, 40)) begin
         if ($urandom_range(0, 99) < 5) next_fresh = 1'b1;
         put_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // directed walk
   typedef struct {
      bit                          is_cfg;
      bit                          mode;
      logic [hcbd_pkg::SIZE_W-1:0] limit;
      bit                          nb;
      logic [7:0]                  data;
      bit                          typed;
      hcbd_pkg::rsp_type           want;
   } dir_row_type;

   dir_row_type dir_rows[$];

   function automatic void add_cfg(bit mode, logic [hcbd_pkg::SIZE_W-1:0] limit);
      dir_row_type r;
      r.is_cfg = 1'b1;
      r.mode   = mode;
      r.limit  = limit;
      r.nb     = 1'b0;
      r.data   = '0;
      r.typed  = 1'b0;
      r.want   = '0;
      dir_rows.insert(dir_rows.size(), r);
   endfunction

   function automatic void add_beat(bit nb, logic [7:0] data);
      dir_row_type r;
      r.is_cfg = 1'b0;
      r.mode   = 1'b0;
      r.limit  = '0;
      r.nb     = nb;
      r.data   = data;
      r.typed  = 1'b0;
      r.want   = '0;
      dir_rows.insert(dir_rows.size(), r);
   endfunction

   function automatic void add_typed(bit nb, logic [7:0] data, bit v, logic [7:0] ob,
                                     bit done, bit ovf,
                                     logic [hcbd_pkg::RCOUNT_W-1:0] cnt);
      add_beat(nb, data);
      dir_rows[$].typed               = 1'b1;
      dir_rows[$].want.out_valid      = v;
      dir_rows[$].want.out_byte       = ob;
      dir_rows[$].want.body_done      = done;
      dir_rows[$].want.overflow       = ovf;
      dir_rows[$].want.received_count = cnt;
   endfunction

   initial begin : stimulus
      bit                          mode;
      logic [hcbd_pkg::SIZE_W-1:0] limit;
      int                          phase_no;
      int                          budget;
      bit                          first;
      bit                          pressed;

      cfg_chunked = 1'b0;
      cfg_limit   = '0;
      clear_decoder();

      // reset values: plain mode, no limit
      add_typed(1'b1, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1);
      add_typed(1'b0, 8'hFF, 1'b1, 8'hFF, 1'b0, 1'b0, 2);
      // chunk of two, stray bytes in every waiting phase, then the trailer
      add_cfg(1'b1, '0);
      add_typed(1'b1, "2", 1'b0, 8'h00, 1'b0, 1'b0, 0);
      add_beat(1'b0, "z");
      add_beat(1'b0, hcbd_pkg::BYTE_CR);
      add_beat(1'b0, "q");
      add_beat(1'b0, hcbd_pkg::BYTE_LF);
      add_typed(1'b0, hcbd_pkg::BYTE_CR, 1'b1, hcbd_pkg::BYTE_CR, 1'b0, 1'b0, 1);
      add_typed(1'b0, hcbd_pkg::BYTE_LF, 1'b1, hcbd_pkg::BYTE_LF, 1'b0, 1'b0, 2);
      add_beat(1'b0, "q");
      add_beat(1'b0, hcbd_pkg::BYTE_CR);
      add_beat(1'b0, "q");
      add_beat(1'b0, hcbd_pkg::BYTE_LF);
      add_beat(1'b0, "0");
      add_beat(1'b0, hcbd_pkg::BYTE_CR);
      add_beat(1'b0, hcbd_pkg::BYTE_LF);
      add_beat(1'b0, "x");
      add_typed(1'b0, hcbd_pkg::BYTE_LF, 1'b0, 8'h00, 1'b1, 1'b0, 2);
      add_typed(1'b0, "A", 1'b0, 8'h00, 1'b1, 1'b0, 2);
      // limit of one byte: the second data byte overflows
      add_cfg(1'b1, 1);
      add_beat(1'b1, "3");
      add_beat(1'b0, hcbd_pkg::BYTE_CR);
      add_beat(1'b0, hcbd_pkg::BYTE_LF);
      add_typed(1'b0, 8'h55, 1'b1, 8'h55, 1'b0, 1'b0, 1);
      add_typed(1'b0, 8'hAA, 1'b0, 8'h00, 1'b1, 1'b1, 2);
      add_cfg(1'b0, '1);
      add_typed(1'b1, 8'h80, 1'b1, 8'h80, 1'b0, 1'b0, 1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            wait_idle();
            program_regs(dir_rows[i].mode, dir_rows[i].limit);
         end else begin
            push_beat(dir_rows[i].nb, dir_rows[i].data, dir_rows[i].typed,
                      dir_rows[i].want);
            idle_maybe();
         end
      end

      live_items = 0;
      phase_no   = 0;
      pressed    = 1'b0;
      while (live_items < RANDOM_ITEMS) begin
         wait_idle();
         if (phase_no == 0) begin
            mode  = 1'b1;
            limit = '0;
         end else if (phase_no == 1) begin
            mode  = 1'b1;
            limit = '1;
         end else if (phase_no == 2) begin
            mode  = 1'b0;
            limit = $urandom_range(1, 60);
         end else begin
            mode = ($urandom_range(0, 99) < 75);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: limit = '0;
               4, 5, 6, 7: limit = $urandom_range(1, 200);
               8:          limit = '1;
               default:    limit = $urandom;
            endcase
         end
         program_regs(mode, limit);
         budget = live_items + $urandom_range(80, 140);
         first  = 1'b1;
         while (live_items < budget && live_items < RANDOM_ITEMS) begin
            // the first body after a setting change may carry on mid-body
            if (mode) chunked_body(!first || $urandom_range(0, 3) != 0);
            else plain_burst(!first || $urandom_range(0, 3) != 0);
            first = 1'b0;
            if (!pressed && live_items >= 600) begin
               wait_idle();
               pressed = 1'b1;
            end
         end
         phase_no++;
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("%0d result beats checked over %0d register settings", beats_checked,
               settings);
      $display("%0d payload bytes delivered, %0d bodies ended, %0d by overflow",
               bytes_out, bodies_ended, overflows);
      if (errors == 0) begin
         $display("http_chunked_body_decoder regression: pass");
      end else begin
         $display("http_chunked_body_decoder regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
               pending_rsp.size());
      $display("http_chunked_body_decoder regression: fail");
      $finish;
   end

endmodule

FILE: files.f
rtl/hcbd_pkg.sv
rtl/hcbd_skid.sv
rtl/http_chunked_body_decoder.sv
dv/tb.sv
